// File: rtl/glpmc_pkg.sv
package glpmc_pkg;

  localparam int MAX_LEN = 4096;
  // priority encoders are 8 groups of 8, so segments and segment count are both 64
  localparam int PE_N    = 64;
  localparam int PE_W    = $clog2(PE_N);
  localparam int SEG_LEN = PE_N;
  localparam int NUM_SEG = MAX_LEN / SEG_LEN;
  localparam int POS_W   = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int CHAR_W  = 8;
  localparam int FLD_W   = 12;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              end_of_string;
  } in_item_t;

  typedef struct packed {
    logic             is_match;
    logic [FLD_W-1:0] match_length;
    logic [FLD_W-1:0] token_value;
    logic             last_token;
  } out_item_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic              clear;
    logic              ext;
    logic              fresh;
    logic              write;
    logic [CHAR_W-1:0] ch;
  } cell_cmd_t;

  typedef struct packed {
    logic            any;
    logic [PE_W-1:0] idx;
  } pe_t;

  // lowest set bit of a 64-bit vector, in two levels of eight
  function automatic pe_t first_set(input logic [PE_N-1:0] v);
    pe_t        r;
    logic [7:0] grp_any;
    logic [2:0] grp_idx [8];
    logic [2:0] g;
    for (int gi = 0; gi < 8; gi++) begin
      grp_any[gi] = |v[gi*8 +: 8];
      grp_idx[gi] = 3'd0;
      for (int b = 7; b >= 0; b--) begin
        if (v[gi*8 + b]) begin
          grp_idx[gi] = 3'(b);
        end
      end
    end
    g = 3'd0;
    for (int gi = 7; gi >= 0; gi--) begin
      if (grp_any[gi]) begin
        g = 3'(gi);
      end
    end
    r.any = |grp_any;
    r.idx = {g, grp_idx[g]};
    return r;
  endfunction

endpackage

// File: rtl/glpmc_cell.sv
module glpmc_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  glpmc_pkg::cell_cmd_t cmd,
  input  logic                 prev_flag,
  input  logic                 prev_wr,
  output logic                 flag,
  output logic                 wr
);
  import glpmc_pkg::*;

  logic              flag_r, flag_nxt;
  logic              wr_r, wr_nxt;
  logic [CHAR_W-1:0] hist_r;
  logic              hit;
  logic              take;

  assign hit  = wr_r && (hist_r == cmd.ch);
  // written cells form a prefix, so the first unwritten one takes the char
  assign take = cmd.write && prev_wr && !wr_r;

  always_comb begin
    flag_nxt = flag_r;
    if (cmd.clear) begin
      flag_nxt = 1'b0;
    end else if (cmd.ext) begin
      // a candidate ending at the left neighbor extends into this cell
      flag_nxt = prev_flag && hit;
    end else if (cmd.fresh) begin
      flag_nxt = hit;
    end
  end

  always_comb begin
    wr_nxt = wr_r;
    if (cmd.clear) begin
      wr_nxt = 1'b0;
    end else if (take) begin
      wr_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
      wr_r   <= 1'b0;
    end else begin
      flag_r <= flag_nxt;
      wr_r   <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hist_r <= cmd.ch;
    end
  end

  assign flag = flag_r;
  assign wr   = wr_r;

endmodule

// File: rtl/glpmc_seg.sv
module glpmc_seg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  glpmc_pkg::cell_cmd_t cmd,
  input  logic                 prev_flag,
  input  logic                 prev_wr,
  output logic                 last_flag,
  output logic                 last_wr,
  output glpmc_pkg::pe_t       stat
);
  import glpmc_pkg::*;

  logic [SEG_LEN-1:0] flag_v;
  logic [SEG_LEN-1:0] wr_v;
  pe_t                stat_r;

  for (genvar k = 0; k < SEG_LEN; k++) begin : g_cell
    if (k == 0) begin : g_head
      glpmc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .prev_flag (prev_flag),
        .prev_wr   (prev_wr),
        .flag      (flag_v[k]),
        .wr        (wr_v[k])
      );
    end else begin : g_body
      glpmc_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .prev_flag (flag_v[k-1]),
        .prev_wr   (wr_v[k-1]),
        .flag      (flag_v[k]),
        .wr        (wr_v[k])
      );
    end
  end

  // first surviving candidate end inside this segment
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_r <= '0;
    end else begin
      stat_r <= first_set(flag_v);
    end
  end

  assign last_flag = flag_v[SEG_LEN-1];
  assign last_wr   = wr_v[SEG_LEN-1];
  assign stat      = stat_r;

endmodule

// File: rtl/greedy_longest_previous_match_coder.sv
// greedy lz77 coder over the whole history of one string
// input channel: in_valid / in_stall / in_data (char_in, end_of_string); a char
// transfers when in_valid is high and in_stall low. output channel: out_valid /
// out_stall / out_data (is_match, match_length, token_value, last_token).
// history sits in a chain of 4096 cells; each cell keeps one char and a flag that
// marks a candidate match ending there, and on every extension a flag moves one
// cell to the right when the cell's char equals the new char.
// timing: a char passes through dispatch, wait1, wait2 and decide before the next
// char is taken; a char that breaks an open match runs wait1, wait2 and decide
// again. tokens enter the output register from decide, and decide waits while a
// stalled token holds it. the wait states cover the two register levels of the
// earliest-candidate search (per 64-cell segment, then over segments). a char
// beyond 4096 is dropped; with end_of_string it still flushes an open match, whose
// token is written from dispatch. reset (rst_n low, synchronous) empties history
// and all candidates; the token with last_token high is written with the same
// clear, so the next char starts a new string. no clearing pass is needed.
// a stalled output holds its token; the coder keeps working until it has the next
// token to write, and then waits for the output register to free up.
module greedy_longest_previous_match_coder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  glpmc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output glpmc_pkg::out_item_t out_data
);
  import glpmc_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_WAIT1    = 3'd2;
  localparam logic [2:0] S_WAIT2    = 3'd3;
  localparam logic [2:0] S_DECIDE   = 3'd4;

  localparam logic PH_EXT   = 1'b0;
  localparam logic PH_FRESH = 1'b1;

  logic [2:0]        state_r, state_nxt;
  logic              phase_r, phase_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [POS_W-1:0]  len_r, len_nxt;
  logic [POS_W-1:0]  old_j_r, old_j_nxt;
  logic [CHAR_W-1:0] c_r;
  logic              last_r;
  logic              any_r;
  logic [POS_W-1:0]  first_e_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  cell_cmd_t         cmd;
  logic              emit;
  out_item_t         emit_item;
  logic              slot_free;
  logic              in_xfer;

  logic [NUM_SEG:0]  flag_chain;
  logic [NUM_SEG:0]  wr_chain;
  pe_t               seg_stat [NUM_SEG];
  logic [NUM_SEG-1:0] seg_any;
  pe_t               top_pe;

  assign flag_chain[0] = 1'b0;
  assign wr_chain[0]   = 1'b1;

  for (genvar s = 0; s < NUM_SEG; s++) begin : g_seg
    glpmc_seg u_seg (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .prev_flag (flag_chain[s]),
      .prev_wr   (wr_chain[s]),
      .last_flag (flag_chain[s+1]),
      .last_wr   (wr_chain[s+1]),
      .stat      (seg_stat[s])
    );
    assign seg_any[s] = seg_stat[s].any;
  end

  assign top_pe = first_set(seg_any);

  // earliest surviving candidate end over the whole history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r     <= 1'b0;
      first_e_r <= '0;
    end else begin
      any_r     <= top_pe.any;
      first_e_r <= {top_pe.idx, seg_stat[top_pe.idx].idx};
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    count_nxt = count_r;
    len_nxt   = len_r;
    old_j_nxt = old_j_r;
    emit      = 1'b0;
    emit_item = '0;
    cmd       = '0;
    cmd.ch    = c_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (count_r == CNT_W'(MAX_LEN)) begin
          // history full: only end of string matters
          if (!last_r) begin
            state_nxt = S_IDLE;
          end else if (len_r != '0) begin
            if (slot_free) begin
              emit                   = 1'b1;
              emit_item.is_match     = 1'b1;
              emit_item.match_length = FLD_W'(len_r);
              emit_item.token_value  = FLD_W'(first_e_r - len_r + POS_W'(1));
              emit_item.last_token   = 1'b1;
              cmd.clear              = 1'b1;
              count_nxt              = '0;
              len_nxt                = '0;
              state_nxt              = S_IDLE;
            end
          end else begin
            cmd.clear = 1'b1;
            count_nxt = '0;
            len_nxt   = '0;
            state_nxt = S_IDLE;
          end
        end else if (len_r != '0) begin
          old_j_nxt = first_e_r - len_r + POS_W'(1);
          cmd.ext   = 1'b1;
          phase_nxt = PH_EXT;
          state_nxt = S_WAIT1;
        end else begin
          cmd.fresh = 1'b1;
          cmd.write = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          phase_nxt = PH_FRESH;
          state_nxt = S_WAIT1;
        end
      end
      S_WAIT1: begin
        state_nxt = S_WAIT2;
      end
      S_WAIT2: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (phase_r == PH_EXT) begin
          if (any_r) begin
            if (!last_r) begin
              cmd.write = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              len_nxt   = len_r + POS_W'(1);
              state_nxt = S_IDLE;
            end else if (slot_free) begin
              emit                   = 1'b1;
              emit_item.is_match     = 1'b1;
              emit_item.match_length = FLD_W'(len_r + POS_W'(1));
              emit_item.token_value  = FLD_W'(first_e_r - len_r);
              emit_item.last_token   = 1'b1;
              cmd.clear              = 1'b1;
              count_nxt              = '0;
              len_nxt                = '0;
              state_nxt              = S_IDLE;
            end
          end else if (slot_free) begin
            // match broken: close it, then parse the same char afresh
            emit                   = 1'b1;
            emit_item.is_match     = 1'b1;
            emit_item.match_length = FLD_W'(len_r);
            emit_item.token_value  = FLD_W'(old_j_r);
            emit_item.last_token   = 1'b0;
            len_nxt                = '0;
            cmd.fresh              = 1'b1;
            cmd.write              = 1'b1;
            count_nxt              = count_r + CNT_W'(1);
            phase_nxt              = PH_FRESH;
            state_nxt              = S_WAIT1;
          end
        end else begin
          if (any_r && !last_r) begin
            len_nxt   = POS_W'(1);
            state_nxt = S_IDLE;
          end else if (slot_free) begin
            emit = 1'b1;
            if (any_r) begin
              emit_item.is_match     = 1'b1;
              emit_item.match_length = FLD_W'(1);
              emit_item.token_value  = FLD_W'(first_e_r);
              emit_item.last_token   = 1'b1;
            end else begin
              emit_item.is_match     = 1'b0;
              emit_item.match_length = '0;
              emit_item.token_value  = FLD_W'(c_r);
              emit_item.last_token   = last_r;
            end
            if (last_r) begin
              cmd.clear = 1'b1;
              count_nxt = '0;
            end
            len_nxt   = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_FRESH;
      count_r <= '0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    old_j_r <= old_j_nxt;
    if (in_xfer) begin
      c_r    <= in_data.char_in;
      last_r <= in_data.end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= emit_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the last cell is written exactly when the history is full
  a_full_tracks_chain: assert property (@(posedge clk) disable iff (!rst_n)
    wr_chain[NUM_SEG] == (count_r == CNT_W'(MAX_LEN)))
    else $error("history fill count disagrees with the cell chain");

  a_flag_needs_char: assert property (@(posedge clk) disable iff (!rst_n)
    flag_chain[NUM_SEG] |-> wr_chain[NUM_SEG])
    else $error("candidate flag set in an unwritten cell");

  a_len_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == '0) || (CNT_W'(len_r) < count_r))
    else $error("open match longer than the stored history");

  a_first_written: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) && any_r |-> (CNT_W'(first_e_r) < count_r))
    else $error("earliest candidate lies beyond the stored history");

  a_literal_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !emit_item.is_match |=> (out_data_r.match_length == '0))
    else $error("literal token carries a nonzero length");

endmodule
